[rtl/core/gpf_pkg.sv]
// shared types, command codes and the 5x7 font table for the glyph renderer
// no dependencies; imported by the front end, back end, top level and testbench
package gpf_pkg;

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [7:0] FIRST_CODE = 8'h20;
    localparam logic [7:0] LAST_CODE  = 8'h7E;
    localparam int GLYPH_W = 5;
    localparam int CELL_W  = 6;
    localparam int GLYPHS  = 95;

    // classified command as it sits in the command queue
    typedef struct packed {
        op_t         op;
        logic [6:0]  x;
        logic [2:0]  page;
        logic [2:0]  scale;
        logic [7:0]  next_x;
        logic        rd_ok;
        logic [39:0] glyph;
    } gpf_cmd_t;

    typedef struct packed {
        logic [7:0] next_x;
        logic [7:0] read_data;
    } gpf_res_t;

    // one glyph per entry, column 0 in bits [7:0], bit 0 of a column is the top pixel
    localparam logic [39:0] FONT [0:GLYPHS-1] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
        40'h0041221C00, 40'h001C224100, 40'h082A1C2A08, 40'h08083E0808,
        40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
        40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
        40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
        40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
        40'h4122140800, 40'h1414141414, 40'h0008142241, 40'h0609510102,
        40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
        40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h325141413E,
        40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
        40'h404040407F, 40'h7F0204027F, 40'h7F1008047F, 40'h3E4141413E,
        40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0304780403, 40'h4345495161, 40'h41417F0000,
        40'h2010080402, 40'h00007F4141, 40'h0402010204, 40'h4040404040,
        40'h0004020100, 40'h7854545420, 40'h384444487F, 40'h2044444438,
        40'h7F48444438, 40'h1854545438, 40'h0201097E08, 40'h3C54545408,
        40'h780404087F, 40'h00407D4400, 40'h003D444020, 40'h4428107F00,
        40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
        40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448,
        40'h2040443F04, 40'h7C4040403C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h3C5050500C, 40'h444C546444, 40'h0041360800,
        40'h00007F0000, 40'h0008364100, 40'h0810080408
    };

    // codes outside the printable range render as space
    function automatic logic [39:0] font_lookup(input logic [7:0] code);
        logic [7:0] idx;
        idx = code - FIRST_CODE;
        if (code >= FIRST_CODE && code <= LAST_CODE)
        begin
            return FONT[idx[6:0]];
        end
        return FONT[0];
    endfunction

endpackage

[rtl/core/gpf_fifo.sv]
// two-entry queue used between front and back and in front of the result ports
// depends on nothing but its width parameter
module gpf_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] rdata
);

    logic [W-1:0] data_reg [2];
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;
    logic         do_push;
    logic         do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/core/gpf_front.sv]
// front end: decodes an incoming transaction into a queued command
// clamps scale, fetches the font row, precomputes next column; uses gpf_pkg
module gpf_front #(
    parameter int COLUMNS   = 128,
    parameter int PAGES     = 8,
    parameter int MAX_SCALE = 4
) (
    input  logic [1:0]       cmd,
    input  logic [6:0]       x_pos,
    input  logic [2:0]       page_row,
    input  logic [7:0]       char_code,
    input  logic [2:0]       scale,
    output gpf_pkg::gpf_cmd_t cmd_word
);

    import gpf_pkg::*;

    logic [2:0] s_eff;
    op_t        op;

    assign op = op_t'(cmd);

    always_comb
    begin
        if (scale == 3'd0)
        begin
            s_eff = 3'd1;
        end
        else if (32'(scale) > MAX_SCALE)
        begin
            s_eff = 3'(MAX_SCALE);
        end
        else
        begin
            s_eff = scale;
        end
    end

    always_comb
    begin
        cmd_word.op    = op;
        cmd_word.x     = x_pos;
        cmd_word.page  = page_row;
        cmd_word.scale = s_eff;
        cmd_word.glyph = font_lookup(char_code);
        cmd_word.rd_ok = (32'(x_pos) < COLUMNS) && (32'(page_row) < PAGES);
        // x + 6*s, wraps at 256
        if (op == OP_DRAW)
        begin
            cmd_word.next_x = {1'b0, x_pos} + {3'b0, s_eff, 2'b0} + {4'b0, s_eff, 1'b0};
        end
        else
        begin
            cmd_word.next_x = 8'd0;
        end
    end

endmodule

[rtl/core/gpf_back.sv]
// back end: runs queued commands on the frame store, clears it after reset
// one byte written per cycle while clearing or drawing; uses gpf_pkg
module gpf_back #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  gpf_pkg::gpf_cmd_t cmd_data,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output gpf_pkg::gpf_res_t res_data,
    output logic              init_busy
);

    import gpf_pkg::*;

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_INIT  = 6'b000010,
        ST_CLEAR = 6'b000100,
        ST_DRAW  = 6'b001000,
        ST_READ  = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    mem_rdata_reg;

    state_t        state_reg;
    state_t        state_next;
    gpf_cmd_t      cur_reg;
    gpf_cmd_t      cur_next;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] clr_next;
    logic [7:0]    col_reg;
    logic [7:0]    col_next;
    logic [2:0]    sub_reg;
    logic [2:0]    sub_next;
    logic [2:0]    gc_reg;
    logic [2:0]    gc_next;
    logic [2:0]    pg_reg;
    logic [2:0]    pg_next;
    logic [2:0]    bit_reg;
    logic [2:0]    bit_next;
    logic [2:0]    rem_reg;
    logic [2:0]    rem_next;

    logic [7:0]    col_bits;
    logic [7:0]    wbyte;
    logic [2:0]    b_walk;
    logic [2:0]    r_walk;
    logic [2:0]    s_last;
    logic [3:0]    dpage;
    logic          draw_in;
    logic [AW-1:0] draw_addr;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    assign s_last    = cur_reg.scale - 3'd1;
    assign dpage     = {1'b0, cur_reg.page} + {1'b0, pg_reg};
    assign draw_in   = (32'(col_reg) < COLUMNS) && (32'(dpage) < PAGES);
    assign draw_addr = AW'(32'(dpage) * COLUMNS + 32'(col_reg));
    assign rd_addr   = AW'(32'(cur_reg.page) * COLUMNS + 32'(cur_reg.x));
    assign init_busy = (state_reg == ST_INIT);

    // gap columns after the fifth glyph column are blank
    assign col_bits = (gc_reg < 3'(GLYPH_W)) ? cur_reg.glyph[{gc_reg, 3'b000} +: 8] : 8'd0;

    // walk the eight rows of this page, each glyph row repeats scale times
    always_comb
    begin
        b_walk = bit_reg;
        r_walk = rem_reg;
        for (int j = 0; j < 8; j++)
        begin
            wbyte[j] = col_bits[b_walk];
            if (r_walk == s_last)
            begin
                r_walk = 3'd0;
                b_walk = b_walk + 3'd1;
            end
            else
            begin
                r_walk = r_walk + 3'd1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        clr_next   = clr_reg;
        col_next   = col_reg;
        sub_next   = sub_reg;
        gc_next    = gc_reg;
        pg_next    = pg_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        we         = 1'b0;
        waddr      = clr_reg;
        wdata      = 8'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd_data;
                    col_next = {1'b0, cmd_data.x};
                    sub_next = 3'd0;
                    gc_next  = 3'd0;
                    pg_next  = 3'd0;
                    bit_next = 3'd0;
                    rem_next = 3'd0;
                    clr_next = '0;
                    unique case (cmd_data.op)
                        OP_DRAW:  state_next = ST_DRAW;
                        OP_READ:  state_next = ST_READ;
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_NONE:  state_next = ST_RESP;
                    endcase
                end
            end
            ST_INIT, ST_CLEAR:
            begin
                we       = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_RESP;
                end
            end
            ST_DRAW:
            begin
                we    = draw_in;
                waddr = draw_addr;
                wdata = wbyte;
                if (pg_reg == s_last)
                begin
                    pg_next  = 3'd0;
                    bit_next = 3'd0;
                    rem_next = 3'd0;
                    col_next = col_reg + 8'd1;
                    if (sub_reg == s_last)
                    begin
                        sub_next = 3'd0;
                        gc_next  = gc_reg + 3'd1;
                        if (gc_reg == 3'(CELL_W - 1))
                        begin
                            state_next = ST_RESP;
                        end
                    end
                    else
                    begin
                        sub_next = sub_reg + 3'd1;
                    end
                end
                else
                begin
                    pg_next  = pg_reg + 3'd1;
                    bit_next = b_walk;
                    rem_next = r_walk;
                end
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_data.next_x    = cur_reg.next_x;
        res_data.read_data = (cur_reg.op == OP_READ && cur_reg.rd_ok) ? mem_rdata_reg : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            clr_reg   <= '0;
            col_reg   <= 8'd0;
            sub_reg   <= 3'd0;
            gc_reg    <= 3'd0;
            pg_reg    <= 3'd0;
            bit_reg   <= 3'd0;
            rem_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            col_reg   <= col_next;
            sub_reg   <= sub_next;
            gc_reg    <= gc_next;
            pg_reg    <= pg_next;
            bit_reg   <= bit_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_rdata_reg <= mem[rd_addr];
    end

endmodule

[rtl/core/glyph_to_page_framebuffer_top.sv]
// glyph renderer into a page-organized frame store; draw, read and clear transactions
// an accepted transaction waits in the command queue until the back end is idle;
// a read then passes the READ state, where the store's read port registers the byte,
// and the RESP state, which pushes the result into the result queue once it has room
// the back end runs one transaction at a time; two more can wait in the command queue
// reset: a clearing pass zeroes all COLUMNS*PAGES bytes, full stays high meanwhile
module glyph_to_page_framebuffer_top #(
    parameter int COLUMNS   = 128,
    parameter int PAGES     = 8,
    parameter int MAX_SCALE = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] cmd,
    input  logic [6:0] x_pos,
    input  logic [2:0] page_row,
    input  logic [7:0] char_code,
    input  logic [2:0] scale,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] next_x,
    output logic [7:0] read_data
);

    import gpf_pkg::*;

    gpf_cmd_t cmd_word;
    gpf_cmd_t cq_data;
    logic     cq_full;
    logic     cq_empty;
    logic     cq_pop;
    gpf_res_t res_in;
    gpf_res_t res_out;
    logic     res_push;
    logic     res_full;
    logic     init_busy;

    assign full = cq_full || init_busy;

    gpf_front #(
        .COLUMNS   (COLUMNS),
        .PAGES     (PAGES),
        .MAX_SCALE (MAX_SCALE)
    ) u_front (
        .cmd       (cmd),
        .x_pos     (x_pos),
        .page_row  (page_row),
        .char_code (char_code),
        .scale     (scale),
        .cmd_word  (cmd_word)
    );

    gpf_fifo #(
        .W ($bits(gpf_cmd_t))
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !init_busy),
        .full  (cq_full),
        .wdata (cmd_word),
        .pop   (cq_pop),
        .empty (cq_empty),
        .rdata (cq_data)
    );

    gpf_back #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cq_empty),
        .cmd_data  (cq_data),
        .cmd_pop   (cq_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in),
        .init_busy (init_busy)
    );

    gpf_fifo #(
        .W ($bits(gpf_res_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_in),
        .pop   (pop),
        .empty (empty),
        .rdata (res_out)
    );

    assign next_x    = res_out.next_x;
    assign read_data = res_out.read_data;

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cq_pop |-> !cq_empty)
        else $error("command popped from an empty queue");

    a_init_no_results: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> empty)
        else $error("result present during the clearing pass");

endmodule

[sim/testbench.sv]
// self-checking testbench for glyph_to_page_framebuffer_top: directed rows, then random traffic
// keeps a shadow copy of the frame store and its own font table to predict each untyped result
// depends on rtl/core/gpf_pkg.sv for op_t and gpf_res_t
module testbench;
    import gpf_pkg::*;

    localparam int FB_COLS      = 128;
    localparam int FB_PAGES     = 8;
    localparam int FB_MAX_SCALE = 4;
    localparam logic [7:0] PRINT_FIRST = 8'h20;
    localparam logic [7:0] PRINT_LAST  = 8'h7E;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 1500000;

    // one glyph per entry, leftmost column in the top byte, bit 0 of a column is the top pixel
    localparam logic [39:0] FONT5X7 [0:94] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h085454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040407C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h0804081008
    };

    typedef struct packed {
        op_t        op;
        logic [6:0] x;
        logic [2:0] page;
        logic [7:0] code;
        logic [2:0] scale;
        logic       typed;
        logic [7:0] nx;
        logic [7:0] rd;
    } dir_row_t;

    // typed rows carry their result, the rest go through the shadow frame
    localparam dir_row_t DIRECTED [0:24] = '{
        '{OP_READ,  7'd0,   3'd0, 8'h00, 3'd1, 1'b1, 8'd0,   8'h00},
        '{OP_READ,  7'd127, 3'd7, 8'h00, 3'd1, 1'b1, 8'd0,   8'h00},
        '{OP_DRAW,  7'd0,   3'd0, 8'h30, 3'd1, 1'b1, 8'd6,   8'h00},
        '{OP_READ,  7'd0,   3'd0, 8'h00, 3'd1, 1'b1, 8'd0,   8'h3E},
        '{OP_READ,  7'd2,   3'd0, 8'h00, 3'd1, 1'b1, 8'd0,   8'h49},
        '{OP_READ,  7'd5,   3'd0, 8'h00, 3'd1, 1'b1, 8'd0,   8'h00},
        '{OP_DRAW,  7'd127, 3'd7, 8'h7E, 3'd4, 1'b1, 8'd151, 8'h00},
        '{OP_READ,  7'd127, 3'd7, 8'h00, 3'd1, 1'b0, 8'd0,   8'h00},
        '{OP_DRAW,  7'd120, 3'd0, 8'hFF, 3'd0, 1'b1, 8'd126, 8'h00},
        '{OP_DRAW,  7'd100, 3'd3, 8'h1F, 3'd7, 1'b1, 8'd124, 8'h00},
        '{OP_DRAW,  7'd10,  3'd6, 8'h41, 3'd2, 1'b1, 8'd22,  8'h00},
        '{OP_READ,  7'd10,  3'd6, 8'h00, 3'd1, 1'b0, 8'd0,   8'h00},
        '{OP_READ,  7'd11,  3'd7, 8'h00, 3'd1, 1'b0, 8'd0,   8'h00},
        '{OP_DRAW,  7'd30,  3'd7, 8'h20, 3'd3, 1'b1, 8'd48,  8'h00},
        '{OP_DRAW,  7'd40,  3'd2, 8'h7F, 3'd1, 1'b1, 8'd46,  8'h00},
        '{OP_DRAW,  7'd60,  3'd1, 8'h57, 3'd3, 1'b1, 8'd78,  8'h00},
        '{OP_DRAW,  7'd63,  3'd1, 8'h2E, 3'd1, 1'b1, 8'd69,  8'h00},
        '{OP_READ,  7'd63,  3'd1, 8'h00, 3'd1, 1'b0, 8'd0,   8'h00},
        '{OP_READ,  7'd62,  3'd2, 8'h00, 3'd1, 1'b0, 8'd0,   8'h00},
        '{OP_NONE,  7'd85,  3'd5, 8'hAA, 3'd5, 1'b1, 8'd0,   8'h00},
        '{OP_CLEAR, 7'd0,   3'd0, 8'h00, 3'd1, 1'b1, 8'd0,   8'h00},
        '{OP_READ,  7'd10,  3'd6, 8'h00, 3'd1, 1'b1, 8'd0,   8'h00},
        '{OP_READ,  7'd60,  3'd1, 8'h00, 3'd1, 1'b1, 8'd0,   8'h00},
        '{OP_DRAW,  7'd0,   3'd0, 8'h7E, 3'd1, 1'b1, 8'd6,   8'h00},
        '{OP_READ,  7'd1,   3'd0, 8'h00, 3'd1, 1'b0, 8'd0,   8'h00}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] cmd = OP_NONE;
    logic [6:0] x_pos = '0;
    logic [2:0] page_row = '0;
    logic [7:0] char_code = '0;
    logic [2:0] scale = '0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] next_x;
    logic [7:0] read_data;

    logic [7:0] shadow_frame [0:FB_COLS*FB_PAGES-1];
    gpf_res_t   pending_results [$];
    int         mismatches = 0;
    int         results_seen = 0;
    int         cycle_count = 0;
    int         items_sent = 0;
    int         tx_quiet = 0;
    int         rx_quiet = 0;
    int         rx_stall = 0;

    glyph_to_page_framebuffer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .x_pos     (x_pos),
        .page_row  (page_row),
        .char_code (char_code),
        .scale     (scale),
        .empty     (empty),
        .pop       (pop),
        .next_x    (next_x),
        .read_data (read_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly no gap or a short one, a few long ones, now and then a stretch with none at all
    function automatic int idle_len(inout int quiet_left);
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // applies one transaction to the shadow frame and returns the result it must produce
    function automatic gpf_res_t frame_apply(input op_t op, input logic [6:0] x,
                                             input logic [2:0] pg, input logic [7:0] code,
                                             input logic [2:0] s);
        gpf_res_t    res;
        int          eff;
        int          gi;
        int          col;
        int          row;
        logic [39:0] glyph;
        logic [7:0]  bits;
        res = '0;
        case (op)
            OP_DRAW:
            begin
                eff = (s == 0) ? 1 : ((s > FB_MAX_SCALE) ? FB_MAX_SCALE : int'(s));
                gi = (code >= PRINT_FIRST && code <= PRINT_LAST) ? int'(code - PRINT_FIRST) : 0;
                glyph = FONT5X7[gi];
                for (int c = 0; c < 6 * eff; c++)
                begin
                    bits = (c / eff < 5) ? glyph[39 - 8 * (c / eff) -: 8] : 8'h00;
                    for (int r = 0; r < 8 * eff; r++)
                    begin
                        col = int'(x) + c;
                        row = int'(pg) * 8 + r;
                        // every pixel of the cell is written, lit or cleared, unless off-screen
                        if (col < FB_COLS && row < 8 * FB_PAGES)
                            shadow_frame[(row / 8) * FB_COLS + col][row % 8] = bits[r / eff];
                    end
                end
                res.next_x = 8'(int'(x) + 6 * eff);
            end
            OP_READ:
                res.read_data = shadow_frame[int'(pg) * FB_COLS + int'(x)];
            OP_CLEAR:
                foreach (shadow_frame[i])
                    shadow_frame[i] = 8'h00;
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // holds one transaction on the input until accepted, then records what it must return
    task automatic issue(input op_t op, input logic [6:0] x, input logic [2:0] pg,
                         input logic [7:0] code, input logic [2:0] s,
                         input logic typed, input gpf_res_t want);
        int       gap;
        gpf_res_t res;
        gap = idle_len(tx_quiet);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        cmd       <= op;
        x_pos     <= x;
        page_row  <= pg;
        char_code <= code;
        scale     <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        res = frame_apply(op, x, pg, code, s);
        pending_results.push_back(typed ? want : res);
        items_sent++;
    endtask

    // result side: check every popped transaction against the oldest expectation
    always @(posedge clk)
    begin
        gpf_res_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d with nothing pending: next_x=%0d read_data=%02h",
                                 results_seen, next_x, read_data);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (next_x !== want.next_x || read_data !== want.read_data)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: next_x exp %0d got %0d, read_data exp %02h got %02h",
                                     results_seen, want.next_x, next_x, want.read_data, read_data);
                    end
                end
                rx_stall = idle_len(rx_quiet);
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("glyph_to_page_framebuffer_top test failed");
            $finish;
        end
    end

    initial
    begin
        logic [6:0] x;
        logic [2:0] pg;
        logic [7:0] code;
        logic [2:0] s;
        int         eff;
        int         r;
        foreach (shadow_frame[i])
            shadow_frame[i] = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            issue(DIRECTED[i].op, DIRECTED[i].x, DIRECTED[i].page, DIRECTED[i].code,
                  DIRECTED[i].scale, DIRECTED[i].typed, {DIRECTED[i].nx, DIRECTED[i].rd});

        while (items_sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                // draw a glyph, then read bytes back at offsets within its cell (wrapped)
                r = $urandom_range(0, 99);
                if (r < 40)
                    s = 3'd1;
                else if (r < 65)
                    s = 3'd2;
                else if (r < 80)
                    s = 3'd3;
                else if (r < 90)
                    s = 3'd4;
                else
                    s = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
                eff = (s == 0) ? 1 : ((s > FB_MAX_SCALE) ? FB_MAX_SCALE : int'(s));
                x = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(100, 127))
                                                : 7'($urandom_range(0, 127));
                pg = 3'($urandom_range(0, 7));
                code = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(32, 126))
                                                     : 8'($urandom_range(0, 255));
                issue(OP_DRAW, x, pg, code, s, 1'b0, '0);
                repeat ($urandom_range(1, 4))
                    issue(OP_READ, 7'(int'(x) + $urandom_range(0, 6 * eff - 1)),
                          3'(int'(pg) + $urandom_range(0, eff - 1)),
                          8'($urandom), 3'($urandom), 1'b0, '0);
            end
            else if (r < 92)
                issue(OP_READ, 7'($urandom), 3'($urandom), 8'($urandom), 3'($urandom), 1'b0, '0);
            else if (r < 96)
                issue(OP_DRAW, 7'($urandom), 3'($urandom), 8'($urandom), 3'($urandom), 1'b0, '0);
            else if (r < 98)
                issue(OP_NONE, 7'($urandom), 3'($urandom), 8'($urandom), 3'($urandom), 1'b0, '0);
            else
                issue(OP_CLEAR, 7'($urandom), 3'($urandom), 8'($urandom), 3'($urandom), 1'b0, '0);
        end
        push <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("glyph_to_page_framebuffer_top test passed");
        else
            $display("glyph_to_page_framebuffer_top test failed");
        $finish;
    end
endmodule
